[hdl/dsfe_pkg.sv]
// Package for the DShot frame encoder: field widths, throttle constants and
// the helper functions that build one 16-bit frame. No dependencies.
package dsfe_pkg;

  localparam int unsigned PctW      = 8;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned ThrW      = 11;
  localparam int unsigned CrcW      = 4;
  localparam int unsigned FrameBits = 16;
  // Slot counter counts 16 bit slots plus the idle slot.
  localparam int unsigned SlotW     = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(FrameBits);

  localparam logic [6:0]      PercentMax = 7'd100;
  localparam logic [ThrW-1:0] ThrMin     = 11'd148;

  // floor(p * 1899 / 100) equals (p * 1899 * 5243) >> 19 for p up to 100:
  // the reciprocal overshoots by at most p * 0.00044, less than the gap p/100
  // between the fraction p*1899/100 and the next integer.
  localparam logic [23:0]     ThrScale   = 24'd9956457;
  localparam int unsigned     ThrShift   = 19;

  localparam logic [DutyW-1:0] OneDutyRst  = 8'd150;
  localparam logic [DutyW-1:0] ZeroDutyRst = 8'd75;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ARMED     = 2'd0,
    CFG_TELEMETRY = 2'd1,
    CFG_ONE_DUTY  = 2'd2,
    CFG_ZERO_DUTY = 2'd3
  } cfg_idx_e;

  function automatic logic [ThrW-1:0] throttle_of(input logic [PctW-1:0] pct,
                                                  input logic            armed);
    logic [6:0]  p;
    logic [30:0] prod;
    logic [ThrW-1:0] thr;
    p    = (pct > {1'b0, PercentMax}) ? PercentMax : pct[6:0];
    prod = 31'(p) * 31'(ThrScale);
    thr  = ThrW'(prod >> ThrShift) + ThrMin;
    if (!armed) begin
      thr = '0;
    end else if (p == 7'd0) begin
      thr = ThrMin;
    end
    return thr;
  endfunction

  function automatic logic [FrameBits-1:0] frame_of(input logic [ThrW-1:0] thr,
                                                    input logic            tel);
    logic [11:0]     q;
    logic [CrcW-1:0] crc;
    q   = {thr, tel};
    crc = q[3:0] ^ q[7:4] ^ q[11:8];
    return {thr, tel, crc};
  endfunction

endpackage

[hdl/dshot_frame_encoder.sv]
// DShot frame encoder top level: turns a throttle percentage into 17 PWM
// compare values (16 bit slots, MSB first, then one idle slot). Uses dsfe_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[7:0] = percent
//  m_axis    out  m_axis_tvalid/tready       tdata[7:0] = duty, tlast = is_last
//  cfg       in   cfg_we_i (no back-pressure) cfg_idx_i, cfg_wdata_i
//
// Each input beat yields 17 output beats, one per cycle while m_axis_tready is
// high; the serializer shifts one bit per cycle under the same condition.
// An input register holds the next percent while the current frame drains,
// so consecutive frames leave with no gap between them.
// Reset is asynchronous and active low; it clears all valid flags and sets
// the registers to disarmed, no telemetry, duties 150 and 75.
// A stall on m_axis holds the output register and the serializer; the input
// register then fills and s_axis_tready drops.
module dshot_frame_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dsfe_pkg::PctW-1:0]      s_axis_tdata,   // [7:0] percent

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dsfe_pkg::DutyW-1:0]     m_axis_tdata,   // [7:0] duty
  output logic                           m_axis_tlast,   // is_last

  input  logic                           cfg_we_i,
  input  logic [dsfe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsfe_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // Configuration registers.
  logic                       armed_q;
  logic                       tel_q;
  logic [dsfe_pkg::DutyW-1:0] one_duty_q;
  logic [dsfe_pkg::DutyW-1:0] zero_duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      tel_q       <= 1'b0;
      one_duty_q  <= dsfe_pkg::OneDutyRst;
      zero_duty_q <= dsfe_pkg::ZeroDutyRst;
    end else if (cfg_we_i) begin
      case (dsfe_pkg::cfg_idx_e'(cfg_idx_i))
        dsfe_pkg::CFG_ARMED:     armed_q     <= cfg_wdata_i[0];
        dsfe_pkg::CFG_TELEMETRY: tel_q       <= cfg_wdata_i[0];
        dsfe_pkg::CFG_ONE_DUTY:  one_duty_q  <= cfg_wdata_i;
        dsfe_pkg::CFG_ZERO_DUTY: zero_duty_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                      in_vld_q;
  logic [dsfe_pkg::PctW-1:0] pct_q;

  // Serializer: frame being shifted out and the slot about to be emitted.
  logic                           ser_vld_q;
  logic [dsfe_pkg::FrameBits-1:0] frame_q;
  logic [dsfe_pkg::SlotW-1:0]     slot_q;

  // Output register.
  logic                       out_vld_q;
  logic [dsfe_pkg::DutyW-1:0] duty_q;
  logic                       last_q;

  logic advance;
  logic ser_load;
  logic in_take;
  logic [dsfe_pkg::FrameBits-1:0] frame_d;

  // The serializer emits a slot whenever the output register is free or being
  // drained, and reloads from the input register after the idle slot.
  assign advance  = ser_vld_q && (!out_vld_q || m_axis_tready);
  assign ser_load = in_vld_q && (!ser_vld_q || (advance && slot_q == dsfe_pkg::LastSlot));
  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !in_vld_q || ser_load;

  assign frame_d = dsfe_pkg::frame_of(dsfe_pkg::throttle_of(pct_q, armed_q), tel_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (ser_load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pct_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      slot_q    <= '0;
    end else if (ser_load) begin
      ser_vld_q <= 1'b1;
      slot_q    <= '0;
    end else if (advance) begin
      ser_vld_q <= (slot_q != dsfe_pkg::LastSlot);
      slot_q    <= slot_q + dsfe_pkg::SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      frame_q <= frame_d;
    end else if (advance) begin
      frame_q <= {frame_q[dsfe_pkg::FrameBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      last_q <= (slot_q == dsfe_pkg::LastSlot);
      if (slot_q == dsfe_pkg::LastSlot) begin
        duty_q <= '0;
      end else begin
        duty_q <= frame_q[dsfe_pkg::FrameBits-1] ? one_duty_q : zero_duty_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = duty_q;
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  // The slot counter never runs past the idle slot while a frame is active.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_vld_q |-> slot_q <= dsfe_pkg::LastSlot)
    else $error("slot counter beyond idle slot");

  // Emitting the idle slot puts a zero-duty last beat into the output register.
  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && slot_q == dsfe_pkg::LastSlot) |=>
      (m_axis_tvalid && m_axis_tlast && m_axis_tdata == '0))
    else $error("idle slot not emitted as zero-duty last beat");

  // A new frame is only started from a held input item.
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ser_vld_q) |-> $past(in_vld_q))
    else $error("serializer started without input item");
`endif

endmodule
